// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    localparam int OPCODE_BITS = 3;
    localparam int STATUS_BITS = 2;

    // operation codes
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_OFFER      = 3'd0,
        OP_PEEK       = 3'd1,
        OP_POLL       = 3'd2,
        OP_READ_AT    = 3'd3,
        OP_REMOVE_TAG = 3'd4,
        OP_REMOVE_AT  = 3'd5
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the input word
        logic cmp;    // run the cell compares, latch the flag vector
        logic exec;   // apply the shift / insert / drop
        logic emit;   // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tag_loop;  // remove by tag still has a matching entry
        logic out_free;  // output register can take a word
    } t_stat;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode; tdata key, tag, position
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser status; tdata key, tag, index, count
// cfg       in   i_cfg_wr_en                   i_cfg_wr_data = order_descending
//
// Each operation runs a parallel compare across all cells, then a shift that inserts
// or drops an entry and loads the output register.
// Remove by tag repeats compare and shift, one matching entry dropped per pass.
// Reset is synchronous, active low; it empties the queue and selects ascending order.
// A full output register stalls the block in the shift step until m_axis_tready.
module sorted_priority_queue #(
    parameter  int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter  int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter  int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    localparam int PW       = $clog2(DEPTH),
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int IN_W     = ((KEY_BITS + TAG_BITS + PW + 7) / 8) * 8,
    localparam int OUT_W    = ((KEY_BITS + TAG_BITS + 2 * CW + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_W-1:0]                 s_axis_tdata,  // entry_key, entry_tag, position
    input  logic [spq_pkg::OPCODE_BITS-1:0] s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata,  // out_key, out_tag,
                                                           // index_or_removed, held_count
    output logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser,  // status
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data
);
    import spq_pkg::*;

    localparam int OUT_USED = KEY_BITS + TAG_BITS + 2 * CW;

    t_cmd  cmd;
    t_stat stat;

    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [CW-1:0]       out_idx;
    logic [CW-1:0]       out_held;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spq_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata[0 +: KEY_BITS]),
        .i_tag         (s_axis_tdata[KEY_BITS +: TAG_BITS]),
        .i_pos         (s_axis_tdata[KEY_BITS + TAG_BITS +: PW]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_key         (out_key),
        .o_tag         (out_tag),
        .o_idx         (out_idx),
        .o_held        (out_held)
    );

    // output word packing
    assign m_axis_tdata[0 +: KEY_BITS]                  = out_key;
    assign m_axis_tdata[KEY_BITS +: TAG_BITS]           = out_tag;
    assign m_axis_tdata[KEY_BITS + TAG_BITS +: CW]      = out_idx;
    assign m_axis_tdata[KEY_BITS + TAG_BITS + CW +: CW] = out_held;

    generate
        if (OUT_W > OUT_USED) begin : g_pad
            assign m_axis_tdata[OUT_W-1:OUT_USED] = '0;
        end
    endgenerate

    // every captured word is compared on the next cycle
    a_load_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.cmp)
        else $error("compare did not follow capture");

    // a result loaded into the output register is presented next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("emitted result not presented");

    // reported count never exceeds the capacity
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_held <= CW'(DEPTH)))
        else $error("held count beyond capacity");

endmodule

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd  o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.tag_loop) begin
                    // drop one match, then compare again
                    o_cmd.exec = 1'b1;
                    n_state    = S_CMP;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/spq_dp.sv =====
module spq_dp #(
    parameter  int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter  int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter  int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    localparam int PW       = $clog2(DEPTH),
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spq_pkg::t_cmd                   i_cmd,
    output spq_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    input  logic [spq_pkg::OPCODE_BITS-1:0] i_op,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [TAG_BITS-1:0]             i_tag,
    input  logic [PW-1:0]                   i_pos,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [spq_pkg::STATUS_BITS-1:0] o_status,
    output logic [KEY_BITS-1:0]             o_key,
    output logic [TAG_BITS-1:0]             o_tag,
    output logic [CW-1:0]                   o_idx,
    output logic [CW-1:0]                   o_held
);
    import spq_pkg::*;

    // configuration and captured operation
    logic                   r_desc;
    logic [OPCODE_BITS-1:0] r_op;
    logic [KEY_BITS-1:0]    r_key;
    logic [TAG_BITS-1:0]    r_tag;
    logic [PW-1:0]          r_pos;
    logic [CW-1:0]          r_removed;

    // entry cells, head at index 0
    logic [KEY_BITS-1:0] r_keys [DEPTH];
    logic [TAG_BITS-1:0] r_tags [DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    // compare results
    logic [DEPTH-1:0]    r_flag;
    logic [DEPTH-1:0]    n_flag;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [TAG_BITS-1:0] r_rd_tag;
    logic [PW-1:0]       rd_idx;

    // shift control
    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] neg;
    logic [DEPTH-1:0] geq;
    logic [DEPTH-1:0] first;
    logic [PW-1:0]    ins_pos;
    logic             pos_ok;
    logic             offer_ok;
    logic             read_ok;
    logic             do_insert;
    logic             do_drop;

    // output register
    logic                   r_ovalid;
    logic [STATUS_BITS-1:0] r_status;
    logic [KEY_BITS-1:0]    r_okey;
    logic [TAG_BITS-1:0]    r_otag;
    logic [CW-1:0]          r_oidx;
    logic [CW-1:0]          r_oheld;
    logic [STATUS_BITS-1:0] n_status;
    logic [CW-1:0]          n_idx;

    // order bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_desc <= i_cfg_wr_data;
        end
    end

    // occupied cells
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid[i] = (CW'(i) < r_count);
        end
    end

    assign pos_ok   = ({{(CW-PW){1'b0}}, r_pos} < r_count);
    assign offer_ok = (r_count != CW'(DEPTH));
    assign rd_idx   = (r_op == OP_PEEK || r_op == OP_POLL) ? '0 : r_pos;

    // per-cell compare: insert point, match, or drop slot
    always_comb begin
        n_flag = '0;
        unique case (r_op)
            OP_OFFER: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (valid[i]) begin
                        n_flag[i] = r_desc ? (r_key > r_keys[i]) : (r_key < r_keys[i]);
                    end else begin
                        n_flag[i] = (CW'(i) == r_count);
                    end
                end
            end
            OP_POLL: n_flag[0] = (r_count != '0);
            OP_REMOVE_AT: begin
                for (int i = 0; i < DEPTH; i++) begin
                    n_flag[i] = pos_ok && (PW'(i) == r_pos);
                end
            end
            OP_REMOVE_TAG: begin
                for (int i = 0; i < DEPTH; i++) begin
                    n_flag[i] = valid[i] && (r_tags[i] == r_tag);
                end
            end
            default: n_flag = '0;
        endcase
    end

    // first flagged cell and every cell at or after it
    assign neg   = ~r_flag + {{(DEPTH-1){1'b0}}, 1'b1};
    assign geq   = r_flag | neg;
    assign first = r_flag & neg;

    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                ins_pos = ins_pos | PW'(i);
            end
        end
    end

    assign do_insert = i_cmd.exec && (r_op == OP_OFFER) && offer_ok;
    assign do_drop   = i_cmd.exec && (|r_flag) &&
                       (r_op == OP_POLL || r_op == OP_REMOVE_AT || r_op == OP_REMOVE_TAG);

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CW'(1);
        end else if (do_drop) begin
            n_count = r_count - CW'(1);
        end
    end

    // result fields
    always_comb begin
        read_ok  = 1'b0;
        n_status = ST_MISS;
        n_idx    = '0;
        unique case (r_op)
            OP_OFFER: begin
                n_status = offer_ok ? ST_OK : ST_FULL;
                if (offer_ok) begin
                    n_idx = {{(CW-PW){1'b0}}, ins_pos};
                end
            end
            OP_PEEK, OP_POLL: begin
                read_ok  = (r_count != '0);
                n_status = read_ok ? ST_OK : ST_MISS;
            end
            OP_READ_AT, OP_REMOVE_AT: begin
                read_ok  = pos_ok;
                n_status = read_ok ? ST_OK : ST_MISS;
            end
            OP_REMOVE_TAG: begin
                n_status = ST_OK;
                n_idx    = r_removed;
            end
            default: n_status = ST_MISS;
        endcase
    end

    // operation capture and compare registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_tag <= i_tag;
            r_pos <= i_pos;
        end
        if (i_cmd.cmp) begin
            r_flag   <= n_flag;
            r_rd_key <= r_keys[rd_idx];
            r_rd_tag <= r_tags[rd_idx];
        end
    end

    // removed counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_removed <= '0;
        end else if (i_cmd.load) begin
            r_removed <= '0;
        end else if (do_drop && r_op == OP_REMOVE_TAG) begin
            r_removed <= r_removed + CW'(1);
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // cell shift: insert opens a gap, drop closes one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_insert) begin
                if (first[i]) begin
                    r_keys[i] <= r_key;
                    r_tags[i] <= r_tag;
                end else if (geq[i] && i > 0) begin
                    r_keys[i] <= r_keys[(i > 0) ? i - 1 : 0];
                    r_tags[i] <= r_tags[(i > 0) ? i - 1 : 0];
                end
            end else if (do_drop) begin
                if (geq[i] && i < DEPTH - 1) begin
                    r_keys[i] <= r_keys[(i < DEPTH - 1) ? i + 1 : i];
                    r_tags[i] <= r_tags[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= n_status;
            r_okey   <= read_ok ? r_rd_key : '0;
            r_otag   <= read_ok ? r_rd_tag : '0;
            r_oidx   <= n_idx;
            r_oheld  <= n_count;
        end
    end

    assign o_stat.tag_loop = (r_op == OP_REMOVE_TAG) && (|r_flag);
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_status;
    assign o_key       = r_okey;
    assign o_tag       = r_otag;
    assign o_idx       = r_oidx;
    assign o_held      = r_oheld;

endmodule

// ===== sim/spq_checker.sv =====
// Watches both stream channels and the order register, keeps its own sorted
// queue, and compares every result word against the oldest prediction.
module spq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // entry_key, entry_tag, position
    input  logic [2:0]  s_axis_tuser,   // opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // out_key, out_tag, index_or_removed, held_count
    input  logic [1:0]  m_axis_tuser,   // status
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);
    import spq_pkg::*;

    typedef struct packed {
        t_status                  status;
        logic [KEY_BITS_DEF-1:0]  key;
        logic [TAG_BITS_DEF-1:0]  tag;
        logic [4:0]               aux;
        logic [4:0]               count;
    } t_answer;

    // shadow of the queue contents, head at slot 0
    logic [KEY_BITS_DEF-1:0] held_keys [DEPTH_DEF];
    logic [TAG_BITS_DEF-1:0] held_tags [DEPTH_DEF];
    int                      held_n;
    logic                    order_desc;

    t_answer answers_due [$];
    int      fails;

    // close the gap left by the entry at slot idx
    function automatic void drop_entry(int idx);
        int i;
        for (i = idx; i + 1 < held_n; i++) begin
            held_keys[i] = held_keys[i + 1];
            held_tags[i] = held_tags[i + 1];
        end
        held_n--;
    endfunction

    // apply one operation to the shadow queue and return the answer it earns
    function automatic t_answer predict_op(logic [2:0] op, logic [31:0] key,
                                           logic [15:0] tag, logic [3:0] pos);
        t_answer r;
        int      w;
        int      i;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_OFFER: begin
                if (held_n >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry goes after all entries with an equal key
                    w = 0;
                    while (w < held_n && !(order_desc ? key > held_keys[w]
                                                      : key < held_keys[w]))
                        w++;
                    for (i = held_n; i > w; i--) begin
                        held_keys[i] = held_keys[i - 1];
                        held_tags[i] = held_tags[i - 1];
                    end
                    held_keys[w] = key;
                    held_tags[w] = tag;
                    held_n++;
                    r.aux = 5'(w);
                end
            end
            OP_PEEK, OP_POLL: begin
                if (held_n == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.key = held_keys[0];
                    r.tag = held_tags[0];
                    if (op == OP_POLL)
                        drop_entry(0);
                end
            end
            OP_READ_AT, OP_REMOVE_AT: begin
                if (int'(pos) >= held_n) begin
                    r.status = ST_MISS;
                end else begin
                    r.key = held_keys[pos];
                    r.tag = held_tags[pos];
                    if (op == OP_REMOVE_AT)
                        drop_entry(int'(pos));
                end
            end
            OP_REMOVE_TAG: begin
                // compact the survivors toward the head
                w = 0;
                for (i = 0; i < held_n; i++) begin
                    if (held_tags[i] == tag) begin
                        r.aux++;
                    end else begin
                        held_keys[w] = held_keys[i];
                        held_tags[w] = held_tags[i];
                        w++;
                    end
                end
                held_n = w;
            end
            default: r.status = ST_MISS;
        endcase
        r.count = 5'(held_n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            held_n     = 0;
            order_desc = 1'b0;
            answers_due.delete();
        end else begin
            if (i_cfg_wr_en)
                order_desc = i_cfg_wr_data;

            // predict on every accepted input word
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(predict_op(s_axis_tuser, s_axis_tdata[31:0],
                                                 s_axis_tdata[47:32], s_axis_tdata[51:48]));

            // compare every accepted result word
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.key    = m_axis_tdata[31:0];
                got.tag    = m_axis_tdata[47:32];
                got.aux    = m_axis_tdata[52:48];
                got.count  = m_axis_tdata[57:53];
                if (answers_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result st=%0d key=%h tag=%h aux=%0d cnt=%0d",
                                 $time, got.status, got.key, got.tag, got.aux, got.count);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status != want.status || got.key != want.key ||
                        got.tag != want.tag || got.aux != want.aux ||
                        got.count != want.count) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch exp st=%0d key=%h tag=%h aux=%0d cnt=%0d",
                                     $time, want.status, want.key, want.tag, want.aux,
                                     want.count);
                            $display("%0t:          got st=%0d key=%h tag=%h aux=%0d cnt=%0d",
                                     $time, got.status, got.key, got.tag, got.aux,
                                     got.count);
                        end
                    end
                end
            end
        end
        o_pending    <= answers_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/testbench.sv =====
// Drives operation words into the queue, flips the order register between
// phases, and leaves all checking to spq_checker.
module testbench;
    import spq_pkg::*;

    // spare opcodes the block must answer with a miss
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int         HOLD_CYCLES = 200;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // entry_key, entry_tag, position
    logic [2:0]  s_axis_tuser  = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // out_key, out_tag, index_or_removed, held_count
    logic [1:0]  m_axis_tuser;         // status
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;

    int fail_count;
    int pending;
    bit quiet     = 1'b0;   // no idling on either side while set
    int hold_reqs = 0;      // bumped to ask the receiver for a long hold-off
    int hold_seen = 0;
    int hold_left = 0;

    always #5 i_clk = ~i_clk;

    sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    spq_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
        end
    end

    // offer one operation word, with a random gap ahead of it
    task automatic send_op(input logic [2:0] op, input logic [31:0] key,
                           input logic [15:0] tag, input logic [3:0] pos);
        while (!quiet && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pos, tag, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering until every result is back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_order(input logic desc);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= desc;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // fill_pct sets the share of offers; the rest spreads over the other ops
    function automatic logic [2:0] pick_op(int fill_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < fill_pct) return OP_OFFER;
        r = $urandom_range(0, 99);
        if (r < 12) return OP_PEEK;
        if (r < 38) return OP_POLL;
        if (r < 56) return OP_READ_AT;
        if (r < 68) return OP_REMOVE_TAG;
        if (r < 99) return OP_REMOVE_AT;
        return $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
    endfunction

    function automatic logic [31:0] pick_key;
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 15);
            2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
        endcase
    endfunction

    initial begin
        int n;
        int ph;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: peek, poll and remove at miss, remove by tag finds nothing
        send_op(OP_PEEK,       32'h0, 16'h0, 4'd0);
        send_op(OP_POLL,       32'h0, 16'h0, 4'd0);
        send_op(OP_REMOVE_AT,  32'h0, 16'h0, 4'd0);
        send_op(OP_REMOVE_TAG, 32'h0, 16'd5, 4'd0);
        // key extremes and an equal-key pair
        send_op(OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
        send_op(OP_OFFER, 32'h0,         16'h0,    4'd0);
        send_op(OP_OFFER, 32'd100,       16'd1,    4'd0);
        send_op(OP_OFFER, 32'd100,       16'd2,    4'd0);
        // index equal to the count
        send_op(OP_READ_AT, 32'h0, 16'h0, 4'd4);
        send_op(OP_RSVD6,   32'h0, 16'h0, 4'd0);
        send_op(OP_RSVD7,   32'h0, 16'h0, 4'd0);
        // fill up, last offer is refused
        for (n = 0; n < 13; n++)
            send_op(OP_OFFER, 32'((n * 37) % 11), 16'(n % 3), 4'd0);
        send_op(OP_READ_AT,    32'h0, 16'h0, 4'd15);
        send_op(OP_REMOVE_AT,  32'h0, 16'h0, 4'd15);
        send_op(OP_REMOVE_TAG, 32'h0, 16'd1, 4'd0);

        // random phases; the order flips while entries are still held
        for (ph = 0; ph < 4; ph++) begin
            set_order(ph[0] ? 1'b0 : 1'b1);
            if (ph == 1)
                hold_reqs++;
            quiet = (ph == 2);
            for (n = 0; n < 250; n++) begin
                if (ph == 2 && n == 150)
                    quiet = 1'b0;
                send_op(pick_op(n < 125 ? 65 : 25), pick_key(),
                        $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 7))
                                                  : 16'($urandom()),
                        $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 3)));
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/sorted_priority_queue.sv
sim/spq_checker.sv
sim/testbench.sv
